// ===== design/bce_pkg.sv =====
// Shared types and constants for the B-spline curve evaluation unit.
package bce_pkg;

    localparam int ORDER_DEF    = 4;
    localparam int MAX_CTRL_DEF = 64;

    localparam logic [1:0] REQ_KNOT = 2'd0;
    localparam logic [1:0] REQ_CTRL = 2'd1;
    localparam logic [1:0] REQ_EVAL = 2'd2;

    localparam logic [1:0] REG_RANGE_START = 2'd0;
    localparam logic [1:0] REG_RANGE_END   = 2'd1;
    localparam logic [1:0] REG_CTRL_COUNT  = 2'd2;

    localparam logic signed [31:0] RANGE_START_RST = 32'sd0;
    localparam logic signed [31:0] RANGE_END_RST   = 32'sd65536;
    localparam logic [6:0]         CTRL_COUNT_RST  = 7'd4;

    // divider: |num| << 16 needs 49 bits
    localparam int DVD_W = 49;
    localparam int CNT_W = 6;

    typedef enum logic [5:0] {
        ST_IDLE, ST_CHECK,
        ST_L1_PRIME, ST_L1_LATCH, ST_L1_RD, ST_L1_WR,
        ST_LV_START, ST_LV_PRIME,
        ST_K0, ST_K1, ST_K2, ST_K3, ST_K4,
        ST_D0, ST_D0_WAIT, ST_D1, ST_D1_WAIT,
        ST_M0, ST_M1, ST_M2,
        ST_FN_START, ST_F0, ST_F1, ST_F2, ST_F3, ST_F4,
        ST_OUT_SUM, ST_EP_RD, ST_EP_OUT, ST_OUT_ERR
    } state_t;

    typedef enum logic [5:0] {
        OP_IDLE, OP_WR_KNOT, OP_WR_CTRL, OP_LOAD,
        OP_L1_PRIME, OP_L1_LATCH, OP_L1_RD, OP_L1_WR,
        OP_LV_START, OP_LV_PRIME,
        OP_K0, OP_K1, OP_K2, OP_K3, OP_K4,
        OP_D0, OP_D0_WAIT, OP_W0_ZERO, OP_D1, OP_D1_WAIT, OP_W1_ZERO,
        OP_M0, OP_M1, OP_M2,
        OP_FN_START, OP_F0, OP_F1, OP_F2, OP_F3, OP_F4,
        OP_OUT_SUM, OP_EP_RD, OP_EP_OUT, OP_OUT_ERR
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic t_eq_start;
        logic t_eq_end;
        logic t_out;
        logic knot_eq0;
        logic knot_eq1;
        logic div_done;
        logic idx_last_l1;
        logic idx_last_lv;
        logic idx_last_fn;
        logic lvl_last;
    } dp_sts_t;

endpackage

// ===== design/bspline_curve_eval_unit.sv =====
// Top level of the B-spline curve evaluation unit with its APB register file.
//
// Knot and control point write items give no result. An evaluate item at an
// endpoint returns that end's control point, one outside the range an error
// status. Any other t sweeps order-1 basis over n+ORDER-1 entries, then for each
// level k = 2..ORDER updates n+ORDER-k entries, each by two 49-step serial
// divisions (each skipped when its weight's knots are equal), then sums the
// control points. busy is high while an evaluate runs; the result stands for one
// cycle with result_valid, and the receiver cannot stall.
module bspline_curve_eval_unit
    import bce_pkg::*;
#(
    parameter int ORDER    = ORDER_DEF,
    parameter int MAX_CTRL = MAX_CTRL_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         req_type,
    input  logic [6:0]         slot,
    input  logic signed [31:0] value_a,
    input  logic signed [31:0] value_b,
    output logic               result_valid,
    output logic               status,
    output logic signed [31:0] point_x,
    output logic signed [31:0] point_y,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic signed [31:0] range_start_reg, range_end_reg;
    logic [6:0]         ctrl_count_reg;
    logic               wr_en;
    dp_cmd_t            cmd;
    dp_sts_t            sts;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_start_reg <= RANGE_START_RST;
            range_end_reg   <= RANGE_END_RST;
            ctrl_count_reg  <= CTRL_COUNT_RST;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_RANGE_START: range_start_reg <= pwdata;
                REG_RANGE_END:   range_end_reg   <= pwdata;
                REG_CTRL_COUNT:  ctrl_count_reg  <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_RANGE_START: prdata = range_start_reg;
            REG_RANGE_END:   prdata = range_end_reg;
            REG_CTRL_COUNT:  prdata = {25'b0, ctrl_count_reg};
            default:         prdata = '0;
        endcase
    end

    bce_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .sts      (sts),
        .cmd      (cmd),
        .busy     (busy)
    );

    bce_dp #(.ORDER(ORDER), .MAX_CTRL(MAX_CTRL)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .slot         (slot),
        .value_a      (value_a),
        .value_b      (value_b),
        .range_start  (range_start_reg),
        .range_end    (range_end_reg),
        .ctrl_count   (ctrl_count_reg),
        .sts          (sts),
        .result_valid (result_valid),
        .status       (status),
        .point_x      (point_x),
        .point_y      (point_y)
    );

endmodule

// ===== design/bce_ram.sv =====
// Generic simple dual-port RAM with registered read.
module bce_ram
    import bce_pkg::*;
#(
    parameter int W     = 32,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/bce_div.sv =====
// Iterative signed Q16.16 divider, one quotient bit per cycle, saturated result.
module bce_div
    import bce_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [32:0] num,
    input  logic signed [32:0] den,
    output logic               done,
    output logic signed [31:0] quo
);

    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [32:0]      dsr_reg, dsr_next;
    logic [33:0]      rem_reg, rem_next;
    logic             neg_reg, neg_next;

    logic [32:0]        num_mag, den_mag;
    logic [33:0]        rem_sh;
    logic               qbit;
    logic signed [49:0] q_signed;

    always_comb
    begin
        num_mag  = num[32] ? 33'(-num) : 33'(num);
        den_mag  = den[32] ? 33'(-den) : 33'(den);
        rem_sh   = {rem_reg[32:0], dvd_reg[DVD_W-1]};
        qbit     = (rem_sh >= {1'b0, dsr_reg});
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            dvd_next = {num_mag, 16'b0};
            dsr_next = den_mag;
            rem_next = '0;
            neg_next = num[32] ^ den[32];
        end
        else if (run_reg)
        begin
            rem_next = qbit ? rem_sh - {1'b0, dsr_reg} : rem_sh;
            dvd_next = {dvd_reg[DVD_W-2:0], qbit};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DVD_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        q_signed = neg_reg ? -$signed({1'b0, dvd_reg}) : $signed({1'b0, dvd_reg});
        if (q_signed > 50'sd2147483647)
        begin
            quo = 32'sh7FFF_FFFF;
        end
        else if (q_signed < -50'sd2147483648)
        begin
            quo = 32'sh8000_0000;
        end
        else
        begin
            quo = q_signed[31:0];
        end
    end

    assign done = done_reg;

endmodule

// ===== design/bce_ctrl.sv =====
// Sequencer for store writes, basis level sweeps and the weighted sum.
module bce_ctrl
    import bce_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] req_type,
    input  dp_sts_t    sts,
    output dp_cmd_t    cmd,
    output logic       busy
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_IDLE;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (req_type)
                        REQ_KNOT: cmd.op = OP_WR_KNOT;
                        REQ_CTRL: cmd.op = OP_WR_CTRL;
                        REQ_EVAL:
                        begin
                            cmd.op     = OP_LOAD;
                            state_next = ST_CHECK;
                        end
                        default: cmd.op = OP_IDLE;
                    endcase
                end
            end
            ST_CHECK:
            begin
                if (sts.t_eq_start || sts.t_eq_end)
                begin
                    state_next = ST_EP_RD;
                end
                else if (sts.t_out)
                begin
                    state_next = ST_OUT_ERR;
                end
                else
                begin
                    state_next = ST_L1_PRIME;
                end
            end
            ST_L1_PRIME:
            begin
                cmd.op     = OP_L1_PRIME;
                state_next = ST_L1_LATCH;
            end
            ST_L1_LATCH:
            begin
                cmd.op     = OP_L1_LATCH;
                state_next = ST_L1_RD;
            end
            ST_L1_RD:
            begin
                cmd.op     = OP_L1_RD;
                state_next = ST_L1_WR;
            end
            ST_L1_WR:
            begin
                cmd.op     = OP_L1_WR;
                state_next = sts.idx_last_l1 ? ST_LV_START : ST_L1_RD;
            end
            ST_LV_START:
            begin
                cmd.op     = OP_LV_START;
                state_next = ST_LV_PRIME;
            end
            ST_LV_PRIME:
            begin
                cmd.op     = OP_LV_PRIME;
                state_next = ST_K0;
            end
            ST_K0:
            begin
                cmd.op     = OP_K0;
                state_next = ST_K1;
            end
            ST_K1:
            begin
                cmd.op     = OP_K1;
                state_next = ST_K2;
            end
            ST_K2:
            begin
                cmd.op     = OP_K2;
                state_next = ST_K3;
            end
            ST_K3:
            begin
                cmd.op     = OP_K3;
                state_next = ST_K4;
            end
            ST_K4:
            begin
                cmd.op     = OP_K4;
                state_next = ST_D0;
            end
            ST_D0:
            begin
                if (sts.knot_eq0)
                begin
                    cmd.op     = OP_W0_ZERO;
                    state_next = ST_D1;
                end
                else
                begin
                    cmd.op     = OP_D0;
                    state_next = ST_D0_WAIT;
                end
            end
            ST_D0_WAIT:
            begin
                cmd.op = OP_D0_WAIT;
                if (sts.div_done)
                begin
                    state_next = ST_D1;
                end
            end
            ST_D1:
            begin
                if (sts.knot_eq1)
                begin
                    cmd.op     = OP_W1_ZERO;
                    state_next = ST_M0;
                end
                else
                begin
                    cmd.op     = OP_D1;
                    state_next = ST_D1_WAIT;
                end
            end
            ST_D1_WAIT:
            begin
                cmd.op = OP_D1_WAIT;
                if (sts.div_done)
                begin
                    state_next = ST_M0;
                end
            end
            ST_M0:
            begin
                cmd.op     = OP_M0;
                state_next = ST_M1;
            end
            ST_M1:
            begin
                cmd.op     = OP_M1;
                state_next = ST_M2;
            end
            ST_M2:
            begin
                cmd.op = OP_M2;
                if (!sts.idx_last_lv)
                begin
                    state_next = ST_K0;
                end
                else if (sts.lvl_last)
                begin
                    state_next = ST_FN_START;
                end
                else
                begin
                    state_next = ST_LV_START;
                end
            end
            ST_FN_START:
            begin
                cmd.op     = OP_FN_START;
                state_next = ST_F0;
            end
            ST_F0:
            begin
                cmd.op     = OP_F0;
                state_next = ST_F1;
            end
            ST_F1:
            begin
                cmd.op     = OP_F1;
                state_next = ST_F2;
            end
            ST_F2:
            begin
                cmd.op     = OP_F2;
                state_next = ST_F3;
            end
            ST_F3:
            begin
                cmd.op     = OP_F3;
                state_next = ST_F4;
            end
            ST_F4:
            begin
                cmd.op     = OP_F4;
                state_next = sts.idx_last_fn ? ST_OUT_SUM : ST_F0;
            end
            ST_OUT_SUM:
            begin
                cmd.op     = OP_OUT_SUM;
                state_next = ST_IDLE;
            end
            ST_EP_RD:
            begin
                cmd.op     = OP_EP_RD;
                state_next = ST_EP_OUT;
            end
            ST_EP_OUT:
            begin
                cmd.op     = OP_EP_OUT;
                state_next = ST_IDLE;
            end
            ST_OUT_ERR:
            begin
                cmd.op     = OP_OUT_ERR;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    a_eval_enters_check: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && req_type == REQ_EVAL |=> state_reg == ST_CHECK)
        else $error("evaluate item did not start a check");

    a_div_done_advances: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_D0_WAIT && sts.div_done |=> state_reg == ST_D1)
        else $error("falling weight division not started after rising weight");

    a_level_loops: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_M2 && !sts.idx_last_lv |=> state_reg == ST_K0)
        else $error("level sweep ended early");

endmodule

// ===== design/bce_dp.sv =====
// Datapath: knot, control and basis stores, divider, multiplier, accumulators.
module bce_dp
    import bce_pkg::*;
#(
    parameter int ORDER    = ORDER_DEF,
    parameter int MAX_CTRL = MAX_CTRL_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    input  logic [6:0]         slot,
    input  logic signed [31:0] value_a,
    input  logic signed [31:0] value_b,
    input  logic signed [31:0] range_start,
    input  logic signed [31:0] range_end,
    input  logic [6:0]         ctrl_count,
    output dp_sts_t            sts,
    output logic               result_valid,
    output logic               status,
    output logic signed [31:0] point_x,
    output logic signed [31:0] point_y
);

    localparam int KNOT_DEPTH = MAX_CTRL + ORDER;
    localparam int BAS_DEPTH  = MAX_CTRL + ORDER - 1;
    localparam int KA_W  = $clog2(KNOT_DEPTH);
    localparam int BA_W  = $clog2(BAS_DEPTH);
    localparam int CA_W  = $clog2(MAX_CTRL);
    localparam int IDX_W = $clog2(KNOT_DEPTH + 1);
    localparam int LVL_W = $clog2(ORDER + 1);
    localparam int N_W   = $clog2(MAX_CTRL + 1);
    localparam int ACC_W = 49 + $clog2(MAX_CTRL);
    localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(-64'sd2147483648);

    function automatic logic signed [47:0] q16_trunc(input logic signed [63:0] p);
        logic signed [63:0] a;
        begin
            a = p[63] ? p + 64'sd65535 : p;
            return a[63:16];
        end
    endfunction

    function automatic logic signed [31:0] sat_acc(input logic signed [ACC_W-1:0] v);
        begin
            if (v > ACC_MAX)
            begin
                return 32'sh7FFF_FFFF;
            end
            else if (v < ACC_MIN)
            begin
                return 32'sh8000_0000;
            end
            return v[31:0];
        end
    endfunction

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [LVL_W-1:0] lvl_reg, lvl_next;
    logic             res_valid_reg;
    logic             res_status_reg;
    logic signed [31:0] res_x_reg, res_y_reg;

    logic signed [31:0] t_reg, ki_reg, ki1_reg, kk1_reg, kk_reg;
    logic signed [31:0] w0_reg, w1_reg, bcur_reg, bnext_reg, cx_reg, cy_reg;
    logic signed [63:0] prod_reg;
    logic signed [47:0] sum_reg;
    logic signed [ACC_W-1:0] accx_reg, accy_reg;

    logic [N_W-1:0]   n_eff;
    logic [IDX_W-1:0] lim_l1, lim_lv, lim_fn, idx_sum;

    logic            knot_we;
    logic [KA_W-1:0] knot_raddr;
    logic [31:0]     knot_rd;
    logic            ctrl_we;
    logic [CA_W-1:0] ctrl_raddr;
    logic [31:0]     x_rd, y_rd;
    logic            bas_we;
    logic [BA_W-1:0] bas_raddr;
    logic [31:0]     bas_wdata, bas_rd;

    logic               div_start, div_done;
    logic signed [32:0] div_num, div_den;
    logic signed [31:0] div_quo;

    logic signed [31:0] ma, mb;
    logic signed [63:0] prod_next;
    logic signed [47:0] prod_tr;
    logic signed [48:0] s49;
    logic signed [31:0] bsat;
    logic               b1;

    // effective control point count
    always_comb
    begin
        if ({25'b0, ctrl_count} < 32'(ORDER))
        begin
            n_eff = N_W'(ORDER);
        end
        else if ({25'b0, ctrl_count} > 32'(MAX_CTRL))
        begin
            n_eff = N_W'(MAX_CTRL);
        end
        else
        begin
            n_eff = N_W'(ctrl_count);
        end
        lim_l1 = IDX_W'(n_eff) + IDX_W'(ORDER - 2);
        lim_lv = IDX_W'(n_eff) + IDX_W'(ORDER - 1) - IDX_W'(lvl_reg);
        lim_fn = IDX_W'(n_eff) - IDX_W'(1);
    end

    always_comb
    begin
        case (cmd.op)
            OP_L1_RD, OP_K1: idx_sum = idx_reg + IDX_W'(1);
            OP_K2:           idx_sum = idx_reg + IDX_W'(lvl_reg) - IDX_W'(1);
            OP_K3:           idx_sum = idx_reg + IDX_W'(lvl_reg);
            default:         idx_sum = idx_reg;
        endcase
        knot_raddr = idx_sum[KA_W-1:0];
        knot_we    = (cmd.op == OP_WR_KNOT) && (32'(slot) < 32'(KNOT_DEPTH));
        ctrl_we    = (cmd.op == OP_WR_CTRL) && (32'(slot) < 32'(MAX_CTRL));
        if (cmd.op == OP_EP_RD)
        begin
            ctrl_raddr = sts.t_eq_start ? '0 : CA_W'(n_eff - N_W'(1));
        end
        else
        begin
            ctrl_raddr = idx_reg[CA_W-1:0];
        end
        case (cmd.op)
            OP_LV_START: bas_raddr = '0;
            OP_K3:       bas_raddr = BA_W'(idx_reg + IDX_W'(1));
            default:     bas_raddr = idx_reg[BA_W-1:0];
        endcase
    end

    // order-1 basis and saturated basis sum
    always_comb
    begin
        b1      = (t_reg >= ki_reg) && (t_reg < $signed(knot_rd));
        prod_tr = q16_trunc(prod_reg);
        s49     = {sum_reg[47], sum_reg} + {prod_tr[47], prod_tr};
        if (s49 > 49'sd2147483647)
        begin
            bsat = 32'sh7FFF_FFFF;
        end
        else if (s49 < -49'sd2147483648)
        begin
            bsat = 32'sh8000_0000;
        end
        else
        begin
            bsat = s49[31:0];
        end
        bas_we    = (cmd.op == OP_L1_WR) || (cmd.op == OP_M2);
        bas_wdata = (cmd.op == OP_L1_WR) ? (b1 ? 32'h0001_0000 : 32'h0) : bsat;
    end

    always_comb
    begin
        div_start = (cmd.op == OP_D0) || (cmd.op == OP_D1);
        if (cmd.op == OP_D0)
        begin
            div_num = {t_reg[31], t_reg} - {ki_reg[31], ki_reg};
            div_den = {kk1_reg[31], kk1_reg} - {ki_reg[31], ki_reg};
        end
        else
        begin
            div_num = {kk_reg[31], kk_reg} - {t_reg[31], t_reg};
            div_den = {kk_reg[31], kk_reg} - {ki1_reg[31], ki1_reg};
        end
    end

    always_comb
    begin
        case (cmd.op)
            OP_M0:
            begin
                ma = w0_reg;
                mb = bcur_reg;
            end
            OP_M1:
            begin
                ma = w1_reg;
                mb = bnext_reg;
            end
            OP_F2:
            begin
                ma = cx_reg;
                mb = bcur_reg;
            end
            default:
            begin
                ma = cy_reg;
                mb = bcur_reg;
            end
        endcase
        prod_next = ma * mb;
    end

    always_comb
    begin
        idx_next = idx_reg;
        lvl_next = lvl_reg;
        case (cmd.op)
            OP_LOAD:
            begin
                idx_next = '0;
                lvl_next = LVL_W'(1);
            end
            OP_L1_WR, OP_M2, OP_F4: idx_next = idx_reg + IDX_W'(1);
            OP_LV_START:
            begin
                idx_next = '0;
                lvl_next = lvl_reg + LVL_W'(1);
            end
            OP_FN_START: idx_next = '0;
            default: idx_next = idx_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            lvl_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            lvl_reg       <= lvl_next;
            res_valid_reg <= (cmd.op == OP_OUT_SUM) || (cmd.op == OP_EP_OUT)
                             || (cmd.op == OP_OUT_ERR);
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                t_reg    <= value_a;
                accx_reg <= '0;
                accy_reg <= '0;
            end
            OP_L1_LATCH, OP_L1_WR, OP_K1: ki_reg <= knot_rd;
            OP_K2:        ki1_reg <= knot_rd;
            OP_K3:        kk1_reg <= knot_rd;
            OP_K4:
            begin
                kk_reg    <= knot_rd;
                bnext_reg <= bas_rd;
            end
            OP_LV_PRIME:  bcur_reg <= bas_rd;
            OP_W0_ZERO:   w0_reg <= '0;
            OP_D0_WAIT:
            begin
                if (div_done)
                begin
                    w0_reg <= div_quo;
                end
            end
            OP_W1_ZERO:   w1_reg <= '0;
            OP_D1_WAIT:
            begin
                if (div_done)
                begin
                    w1_reg <= div_quo;
                end
            end
            OP_M0:        prod_reg <= prod_next;
            OP_M1:
            begin
                sum_reg  <= prod_tr;
                prod_reg <= prod_next;
            end
            OP_M2:        bcur_reg <= bnext_reg;
            OP_F1:
            begin
                cx_reg   <= x_rd;
                cy_reg   <= y_rd;
                bcur_reg <= bas_rd;
            end
            OP_F2:        prod_reg <= prod_next;
            OP_F3:
            begin
                accx_reg <= accx_reg + ACC_W'(prod_tr);
                prod_reg <= prod_next;
            end
            OP_F4:        accy_reg <= accy_reg + ACC_W'(prod_tr);
            OP_OUT_SUM:
            begin
                res_status_reg <= 1'b0;
                res_x_reg      <= sat_acc(accx_reg);
                res_y_reg      <= sat_acc(accy_reg);
            end
            OP_EP_OUT:
            begin
                res_status_reg <= 1'b0;
                res_x_reg      <= x_rd;
                res_y_reg      <= y_rd;
            end
            OP_OUT_ERR:
            begin
                res_status_reg <= 1'b1;
                res_x_reg      <= '0;
                res_y_reg      <= '0;
            end
            default: ;
        endcase
    end

    bce_ram #(.W(32), .DEPTH(KNOT_DEPTH)) u_knot_ram (
        .clk   (clk),
        .we    (knot_we),
        .waddr (KA_W'(slot)),
        .wdata (value_a),
        .raddr (knot_raddr),
        .rdata (knot_rd)
    );

    bce_ram #(.W(32), .DEPTH(MAX_CTRL)) u_ctrl_x_ram (
        .clk   (clk),
        .we    (ctrl_we),
        .waddr (CA_W'(slot)),
        .wdata (value_a),
        .raddr (ctrl_raddr),
        .rdata (x_rd)
    );

    bce_ram #(.W(32), .DEPTH(MAX_CTRL)) u_ctrl_y_ram (
        .clk   (clk),
        .we    (ctrl_we),
        .waddr (CA_W'(slot)),
        .wdata (value_b),
        .raddr (ctrl_raddr),
        .rdata (y_rd)
    );

    // basis values of the current level, updated in place
    bce_ram #(.W(32), .DEPTH(BAS_DEPTH)) u_basis_ram (
        .clk   (clk),
        .we    (bas_we),
        .waddr (idx_reg[BA_W-1:0]),
        .wdata (bas_wdata),
        .raddr (bas_raddr),
        .rdata (bas_rd)
    );

    bce_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        sts.t_eq_start  = (t_reg == range_start);
        sts.t_eq_end    = (t_reg == range_end);
        sts.t_out       = (t_reg < range_start) || (t_reg > range_end);
        sts.knot_eq0    = (ki_reg == kk1_reg);
        sts.knot_eq1    = (ki1_reg == kk_reg);
        sts.div_done    = div_done;
        sts.idx_last_l1 = (idx_reg == lim_l1);
        sts.idx_last_lv = (idx_reg == lim_lv);
        sts.idx_last_fn = (idx_reg == lim_fn);
        sts.lvl_last    = (lvl_reg == LVL_W'(ORDER));
    end

    assign result_valid = res_valid_reg;
    assign status       = res_status_reg;
    assign point_x      = res_x_reg;
    assign point_y      = res_y_reg;

endmodule
